// ===== sv/clit_pkg.sv =====
`default_nettype none

package clit_pkg;

    typedef enum logic [2:0] {
        KIND_INSERT     = 3'd0,
        KIND_REMOVE     = 3'd1,
        KIND_SET        = 3'd2,
        KIND_DOMINATES  = 3'd3,
        KIND_EXACT      = 3'd4,
        KIND_READ_LEFT  = 3'd5,
        KIND_READ_RIGHT = 3'd6,
        KIND_CLEAR      = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  alpha;
        logic [9:0]  beta;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [9:0]  level;
        logic [10:0] left_entries;
        logic        is_empty;
    } out_item_t;

    // write decision of one table for the current beat
    typedef struct packed {
        logic we;
        logic inc;
    } upd_t;

endpackage

`default_nettype wire

// ===== sv/clit_ram.sv =====
`default_nettype none

module clit_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/clit_update.sv =====
`default_nettype none

module clit_update #(
    parameter int LEVEL_BITS = 10
) (
    input  wire logic                  en,
    input  wire logic                  key_ok,
    input  wire clit_pkg::kind_t       mode,
    input  wire logic [LEVEL_BITS:0]   rd_entry,
    input  wire logic [LEVEL_BITS-1:0] val,
    output clit_pkg::upd_t             upd,
    output logic      [LEVEL_BITS:0]   wr_entry
);

    logic                  present;
    logic [LEVEL_BITS-1:0] cur;
    logic [LEVEL_BITS-1:0] nxt;

    assign present = rd_entry[LEVEL_BITS];
    assign cur     = rd_entry[LEVEL_BITS-1:0];

    always_comb begin
        nxt = val;
        if (present) begin
            case (mode)
                clit_pkg::KIND_INSERT: nxt = (cur < val) ? val : cur;
                clit_pkg::KIND_REMOVE: nxt = (cur > val) ? val : cur;
                default:               nxt = val;
            endcase
        end
    end

    // set touches only entries already present
    assign upd.we  = en && key_ok && (present || (mode != clit_pkg::KIND_SET));
    assign upd.inc = en && key_ok && !present && (mode != clit_pkg::KIND_SET);
    assign wr_entry = {1'b1, nxt};

endmodule

`default_nettype wire

// ===== sv/core_level_index_table.sv =====
// An accepted input beat is held while the state machine goes from IDLE to
// LOOK, and the result is registered from LOOK; LOOK lasts longer while an
// earlier result waits for m_ready. A new item is taken only in IDLE, after
// the read-modify-write of each table entry through a synchronous RAM read.
// Reset and the clear kind each start a sweep over all KEY_COUNT entries that
// zeroes both tables; s_ready stays low during the sweep.
`default_nettype none

module core_level_index_table #(
    parameter int KEY_COUNT  = 1024,
    parameter int LEVEL_BITS = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire clit_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output clit_pkg::out_item_t       m_data
);

    localparam int KW        = $clog2(KEY_COUNT);
    localparam int CW        = $clog2(KEY_COUNT + 1);
    localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;

    clit_pkg::state_t    state_reg, state_next;
    clit_pkg::in_item_t  item_reg, item_next;
    logic [KW-1:0]       sweep_reg, sweep_next;
    logic [CW-1:0]       left_total_reg, left_total_next;
    logic [CW-1:0]       right_total_reg, right_total_next;
    logic                m_valid_reg, m_valid_next;
    clit_pkg::out_item_t m_data_reg, m_data_next;

    logic                  out_free;
    logic                  step;
    logic                  is_write;
    logic                  l_ok, r_ok;
    logic                  gt, lt;
    logic [LEVEL_BITS-1:0] sa, sb;
    logic [LEVEL_BITS:0]   l_rd, r_rd;
    logic                  l_pres, r_pres;
    logic [LEVEL_BITS-1:0] l_lvl, r_lvl;
    logic                  l_exact, r_exact;
    clit_pkg::upd_t        l_upd, r_upd;
    logic [LEVEL_BITS:0]   l_wr_entry, r_wr_entry;

    logic                  l_wr_en, r_wr_en;
    logic [KW-1:0]         l_wr_addr, r_wr_addr;
    logic [LEVEL_BITS:0]   l_wr_data, r_wr_data;
    logic [KW-1:0]         l_rd_addr, r_rd_addr;

    // ---- decode of the held item ----
    assign out_free = !m_valid_reg || m_ready;
    assign step     = (state_reg == clit_pkg::ST_LOOK) && out_free;
    assign is_write = (item_reg.kind == clit_pkg::KIND_INSERT) ||
                      (item_reg.kind == clit_pkg::KIND_REMOVE) ||
                      (item_reg.kind == clit_pkg::KIND_SET);

    assign gt   = item_reg.alpha > item_reg.beta;
    assign lt   = item_reg.alpha < item_reg.beta;
    assign l_ok = 32'(item_reg.beta) < KEY_COUNT;
    assign r_ok = 32'(item_reg.alpha) < KEY_COUNT;
    assign sa   = (32'(item_reg.alpha) > LEVEL_MAX) ? LEVEL_BITS'(LEVEL_MAX)
                                                    : LEVEL_BITS'(item_reg.alpha);
    assign sb   = (32'(item_reg.beta) > LEVEL_MAX) ? LEVEL_BITS'(LEVEL_MAX)
                                                   : LEVEL_BITS'(item_reg.beta);

    assign l_pres  = l_ok && l_rd[LEVEL_BITS];
    assign r_pres  = r_ok && r_rd[LEVEL_BITS];
    assign l_lvl   = l_rd[LEVEL_BITS-1:0];
    assign r_lvl   = r_rd[LEVEL_BITS-1:0];
    assign l_exact = l_pres && (l_lvl == sa);
    assign r_exact = r_pres && (r_lvl == sb);

    // ---- tables ----
    clit_ram #(.WIDTH(LEVEL_BITS + 1), .DEPTH(KEY_COUNT)) u_left_ram (
        .aclk    (aclk),
        .wr_en   (l_wr_en),
        .wr_addr (l_wr_addr),
        .wr_data (l_wr_data),
        .rd_addr (l_rd_addr),
        .rd_data (l_rd)
    );

    clit_ram #(.WIDTH(LEVEL_BITS + 1), .DEPTH(KEY_COUNT)) u_right_ram (
        .aclk    (aclk),
        .wr_en   (r_wr_en),
        .wr_addr (r_wr_addr),
        .wr_data (r_wr_data),
        .rd_addr (r_rd_addr),
        .rd_data (r_rd)
    );

    // left keyed by beta holds alpha; right keyed by alpha holds beta
    clit_update #(.LEVEL_BITS(LEVEL_BITS)) u_left_upd (
        .en       (is_write && !lt),
        .key_ok   (l_ok),
        .mode     (item_reg.kind),
        .rd_entry (l_rd),
        .val      (sa),
        .upd      (l_upd),
        .wr_entry (l_wr_entry)
    );

    clit_update #(.LEVEL_BITS(LEVEL_BITS)) u_right_upd (
        .en       (is_write && !gt),
        .key_ok   (r_ok),
        .mode     (item_reg.kind),
        .rd_entry (r_rd),
        .val      (sb),
        .upd      (r_upd),
        .wr_entry (r_wr_entry)
    );

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            clit_pkg::ST_SWEEP: begin
                if (sweep_reg == KW'(KEY_COUNT - 1)) begin
                    state_next = clit_pkg::ST_IDLE;
                end
            end
            clit_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = clit_pkg::ST_LOOK;
                end
            end
            clit_pkg::ST_LOOK: begin
                if (out_free) begin
                    state_next = (item_reg.kind == clit_pkg::KIND_CLEAR) ?
                                 clit_pkg::ST_SWEEP : clit_pkg::ST_IDLE;
                end
            end
            default: state_next = clit_pkg::ST_IDLE;
        endcase
    end

    // ---- outputs and RAM ports ----
    always_comb begin
        s_ready   = 1'b0;
        l_wr_en   = 1'b0;
        r_wr_en   = 1'b0;
        l_wr_addr = KW'(item_reg.beta);
        r_wr_addr = KW'(item_reg.alpha);
        l_wr_data = l_wr_entry;
        r_wr_data = r_wr_entry;
        // hold the read address while a result waits so the read data holds
        l_rd_addr = KW'(item_reg.beta);
        r_rd_addr = KW'(item_reg.alpha);
        case (state_reg)
            clit_pkg::ST_SWEEP: begin
                l_wr_en   = 1'b1;
                r_wr_en   = 1'b1;
                l_wr_addr = sweep_reg;
                r_wr_addr = sweep_reg;
                l_wr_data = '0;
                r_wr_data = '0;
            end
            clit_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                l_rd_addr = KW'(s_data.beta);
                r_rd_addr = KW'(s_data.alpha);
            end
            clit_pkg::ST_LOOK: begin
                l_wr_en = out_free && l_upd.we;
                r_wr_en = out_free && r_upd.we;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---- counters, item and result ----
    assign sweep_next = (state_reg == clit_pkg::ST_SWEEP) ? sweep_reg + KW'(1) : '0;
    assign item_next  = (s_valid && s_ready) ? s_data : item_reg;

    always_comb begin
        left_total_next  = left_total_reg;
        right_total_next = right_total_reg;
        if (step) begin
            if (item_reg.kind == clit_pkg::KIND_CLEAR) begin
                left_total_next  = '0;
                right_total_next = '0;
            end else begin
                left_total_next  = left_total_reg + CW'(l_upd.inc);
                right_total_next = right_total_reg + CW'(r_upd.inc);
            end
        end
    end

    always_comb begin
        m_data_next.hit   = 1'b0;
        m_data_next.level = '0;
        case (item_reg.kind)
            clit_pkg::KIND_DOMINATES: begin
                m_data_next.hit = gt ? (l_pres && (l_lvl >= sa))
                                     : (r_pres && (r_lvl >= sb));
            end
            clit_pkg::KIND_EXACT: begin
                m_data_next.hit = gt ? l_exact : (lt ? r_exact : (l_exact || r_exact));
            end
            clit_pkg::KIND_READ_LEFT: begin
                m_data_next.level = l_pres ? 10'(l_lvl) : 10'd0;
            end
            clit_pkg::KIND_READ_RIGHT: begin
                m_data_next.level = r_pres ? 10'(r_lvl) : 10'd0;
            end
            default: begin
                m_data_next.hit = 1'b0;
            end
        endcase
        m_data_next.left_entries = 11'(left_total_next);
        m_data_next.is_empty     = (left_total_next == '0) && (right_total_next == '0);
    end

    assign m_valid_next = step ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= clit_pkg::ST_SWEEP;
            sweep_reg       <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            left_total_reg  <= left_total_next;
            right_total_reg <= right_total_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (step) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == clit_pkg::ST_LOOK))
        else $error("accepted beat did not start a table lookup");

    a_result_from_look: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == clit_pkg::ST_LOOK))
        else $error("result appeared without a lookup");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_total_reg <= CW'(KEY_COUNT)) && (right_total_reg <= CW'(KEY_COUNT)))
        else $error("entry count exceeds table size");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_empty) |-> (m_data.left_entries == 11'd0))
        else $error("empty result with nonzero left count");
`endif

endmodule

`default_nettype wire
